// ===== hdl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// shared geometry, codes and controller/datapath interface types for the
// text console cell writer
// ----------------------------------------------------------------------------
package tccw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int CELL_AW = $clog2(CELLS);
    localparam int PTR_W   = $clog2(CELLS + 1);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;

    localparam logic [7:0] ATTR_RESET = 8'h0F;
    localparam int         TAB_STEP   = 4;

    // control characters
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted transaction
        logic exec;       // carry out the captured operation
        logic copy;       // scroll copy step at the sweep pointer
        logic fill;       // fill step at the sweep pointer
        logic fill_zero;  // fill with zero instead of the clear style
        logic done;       // present the result next cycle
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic scroll;     // put character ran past the last row
        logic copy_last;  // sweep pointer at the last source row cell
        logic fill_last;  // fill write at the last cell is taking place
    } t_status;

endpackage

// ===== hdl/tccw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccw_ctrl
// sequencing state machine: reset clearing pass, operation dispatch,
// scroll and clear sweeps
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tccw_pkg::t_status i_status,
    output tccw_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import tccw_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_SCROLL = 7'b0010000,
        S_ZERO   = 7'b0100000,
        S_FILL   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_zero = 1'b1;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_status.op)
                    OP_PUT: begin
                        if (i_status.scroll) begin
                            n_state = S_SCROLL;
                        end else begin
                            o_cmd.done = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    OP_CLEAR: begin
                        n_state = S_FILL;
                    end
                    OP_SET: begin
                        o_cmd.done = 1'b1;
                        n_state    = S_IDLE;
                    end
                    default: begin
                        n_state = S_READ;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCROLL: begin
                o_cmd.copy = 1'b1;
                if (i_status.copy_last) begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_zero = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_EXEC))
        else $error("accepted transaction did not reach execute");

    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_INIT) |-> !o_cmd.done)
        else $error("result issued outside an operation");

    a_scroll_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && i_status.op == OP_PUT && i_status.scroll)
        |=> (r_state == S_SCROLL))
        else $error("scroll request not followed by scroll sweep");

endmodule

// ===== hdl/tccw_datapath.sv =====
// ----------------------------------------------------------------------------
// tccw_datapath
// screen memory, cursor, attribute register, sweep pointer and result
// registers
// ----------------------------------------------------------------------------
module tccw_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tccw_pkg::t_cmd                    i_cmd,
    output tccw_pkg::t_status                 o_status,
    input  logic [1:0]                        i_operation,
    input  logic [7:0]                        i_char_code,
    input  logic [7:0]                        i_fill_style,
    input  logic [tccw_pkg::COL_W-1:0]        i_new_col,
    input  logic [tccw_pkg::ROW_W-1:0]        i_new_row,
    input  logic [tccw_pkg::ADDR_W-1:0]       i_cell_address,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [7:0]                        i_cfg_data,
    output logic                              o_result_valid,
    output logic [tccw_pkg::COL_W-1:0]        o_cursor_col_out,
    output logic [tccw_pkg::ROW_W-1:0]        o_cursor_row_out,
    output logic [tccw_pkg::CELL_W-1:0]       o_read_data
);
    import tccw_pkg::*;

    logic [CELL_W-1:0]  r_mem [CELLS];
    logic [CELL_W-1:0]  r_rdata;

    // captured transaction
    t_op                r_op;
    logic [7:0]         r_char;
    logic [7:0]         r_style;
    logic [COL_W-1:0]   r_ncol;
    logic [ROW_W-1:0]   r_nrow;
    logic [ADDR_W-1:0]  r_addr;

    logic [7:0]         r_attr;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [PTR_W-1:0]   r_ptr;
    logic               r_cp_pend;
    logic [CELL_AW-1:0] r_cp_addr;
    logic               r_done;
    logic [CELL_W-1:0]  r_rd_data;

    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic               put_scroll;
    logic               is_ctrl;
    logic               char_we;
    logic               fill_we;
    logic [CELL_AW-1:0] ptr_idx;
    logic [CELL_AW-1:0] here;
    logic [CELL_AW-1:0] raddr;
    logic [CELL_W-1:0]  fill_word;

    assign ptr_idx   = r_ptr[CELL_AW-1:0];
    assign here      = CELL_AW'(r_row) * CELL_AW'(COLUMNS) + CELL_AW'(r_col);
    assign raddr     = i_cmd.copy ? (ptr_idx + CELL_AW'(COLUMNS)) : r_addr[CELL_AW-1:0];
    assign fill_word = i_cmd.fill_zero ? '0 : {r_style, 8'h00};
    assign is_ctrl   = (r_char == CH_BS) || (r_char == CH_TAB) ||
                       (r_char == CH_LF) || (r_char == CH_CR);
    assign char_we   = i_cmd.exec && (r_op == OP_PUT) && !is_ctrl;
    assign fill_we   = i_cmd.fill && !r_cp_pend;

    // put character cursor movement with the clamp and split of the position
    always_comb begin
        logic [COL_W:0] col_w;
        logic [ROW_W:0] row_w;
        col_w = {1'b0, r_col};
        row_w = {1'b0, r_row};
        case (r_char)
            CH_BS: begin
                if (r_col != '0) begin
                    col_w = col_w - 1'b1;
                end else if (r_row != '0) begin
                    col_w = (COL_W + 1)'(COLUMNS - 1);
                    row_w = row_w - 1'b1;
                end
            end
            CH_TAB: begin
                col_w = col_w + (COL_W + 1)'(TAB_STEP);
                if (col_w >= (COL_W + 1)'(COLUMNS)) begin
                    col_w = col_w - (COL_W + 1)'(COLUMNS);
                    row_w = row_w + 1'b1;
                end
            end
            CH_LF: begin
                row_w = row_w + 1'b1;
            end
            CH_CR: begin
                col_w = '0;
            end
            default: begin
                col_w = col_w + 1'b1;
                if (col_w == (COL_W + 1)'(COLUMNS)) begin
                    col_w = '0;
                    row_w = row_w + 1'b1;
                end
            end
        endcase
        put_scroll = (row_w >= (ROW_W + 1)'(ROWS));
        if (put_scroll) begin
            n_col = '0;
            n_row = ROW_W'(ROWS - 1);
        end else begin
            n_col = col_w[COL_W-1:0];
            n_row = row_w[ROW_W-1:0];
        end
    end

    // single write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_cp_pend) begin
            r_mem[r_cp_addr] <= r_rdata;
        end else if (fill_we) begin
            r_mem[ptr_idx] <= fill_word;
        end else if (char_we) begin
            r_mem[here] <= {r_attr, r_char};
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_operation);
            r_char  <= i_char_code;
            r_style <= i_fill_style;
            r_ncol  <= i_new_col;
            r_nrow  <= i_new_row;
            r_addr  <= i_cell_address;
        end
        r_cp_addr <= ptr_idx;
        if (i_cmd.done) begin
            if (r_op == OP_READ && r_addr < ADDR_W'(CELLS)) begin
                r_rd_data <= r_rdata;
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= ATTR_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_ptr     <= '0;
            r_cp_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done    <= i_cmd.done;
            r_cp_pend <= i_cmd.copy;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_ptr <= '0;
            end else if (i_cmd.copy || fill_we) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_PUT: begin
                        r_col <= n_col;
                        r_row <= n_row;
                    end
                    OP_CLEAR: begin
                        r_col <= '0;
                        r_row <= '0;
                    end
                    OP_SET: begin
                        r_col <= (r_ncol > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : r_ncol;
                        r_row <= (r_nrow > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : r_nrow;
                    end
                    default: begin
                        r_col <= r_col;
                        r_row <= r_row;
                    end
                endcase
            end
        end
    end

    assign o_status.op        = r_op;
    assign o_status.scroll    = put_scroll;
    assign o_status.copy_last = (r_ptr == PTR_W'(CELLS - COLUMNS - 1));
    assign o_status.fill_last = !r_cp_pend && (r_ptr == PTR_W'(CELLS - 1));

    assign o_cfg_ready      = 1'b1;
    assign o_result_valid   = r_done;
    assign o_cursor_col_out = r_col;
    assign o_cursor_row_out = r_row;
    assign o_read_data      = r_rd_data;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < COL_W'(COLUMNS)) && (r_row < ROW_W'(ROWS)))
        else $error("cursor left the screen");

    a_copy_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> !char_we)
        else $error("cell write collides with scroll copy");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe longer than one cycle");

endmodule

// ===== hdl/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// text mode console: 16-bit cells (attribute high byte, character low byte),
// put character with backspace/tab/newline/return controls, clear, set
// cursor and read cell
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+---------------------------
//  command   | in        | start high while busy low      | operation, char_code,
//            |           |                                | fill_style, new_col,
//            |           |                                | new_row, cell_address
//  result    | out       | o_result_valid, one cycle      | cursor_col_out,
//            |           |                                | cursor_row_out, read_data
//  config    | in        | i_cfg_valid and o_cfg_ready    | text attribute byte
//
//  put character and set cursor complete in the execute state, read cell adds a
//  state for the registered memory read; clear and a put character that
//  scrolls sweep the screen memory through its single write port, one cell
//  per cycle; after a scroll copy the zero fill waits for the last copy write
//  after reset a clearing pass writes zero to all CELLS cells
//  with busy high; configuration writes are taken throughout
//  the result strobe lasts one cycle and the receiver cannot stall it; a new
//  transaction may be accepted in the same cycle as the strobe
// ----------------------------------------------------------------------------
module text_console_cell_writer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_operation,
    input  logic [7:0]                        i_char_code,
    input  logic [7:0]                        i_fill_style,
    input  logic [tccw_pkg::COL_W-1:0]        i_new_col,
    input  logic [tccw_pkg::ROW_W-1:0]        i_new_row,
    input  logic [tccw_pkg::ADDR_W-1:0]       i_cell_address,
    // result channel
    output logic                              o_result_valid,
    output logic [tccw_pkg::COL_W-1:0]        o_cursor_col_out,
    output logic [tccw_pkg::ROW_W-1:0]        o_cursor_row_out,
    output logic [tccw_pkg::CELL_W-1:0]       o_read_data,
    // attribute register write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [7:0]                        i_cfg_data
);
    import tccw_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: clearing pass, dispatch, scroll and clear sweeps
    tccw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // screen memory, cursor, attribute and result registers
    tccw_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_operation      (i_operation),
        .i_char_code      (i_char_code),
        .i_fill_style     (i_fill_style),
        .i_new_col        (i_new_col),
        .i_new_row        (i_new_row),
        .i_cell_address   (i_cell_address),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out),
        .o_read_data      (o_read_data)
    );

endmodule
